@@ rtl/core/heater_safety_interlock_defines.svh @@
// ----------------------------------------------------------------------------
// heater_safety_interlock_defines.svh
// Assertion macros for the heater safety interlock.
// ----------------------------------------------------------------------------
`ifndef HEATER_SAFETY_INTERLOCK_DEFINES_SVH
`define HEATER_SAFETY_INTERLOCK_DEFINES_SVH

`ifndef SYNTHESIS

// property checked every clock, masked while reset is held
`define HSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked every clock, reset included
`define HSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HSI_ASSERT(lbl, prop, msg)
`define HSI_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/hsi_pkg.sv @@
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared types and constants for the heater safety interlock.
// ----------------------------------------------------------------------------
package hsi_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 72;
  localparam int OutDataW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_EMERGENCY_HOLD = 3'd0,
    CFG_FUSE_SAMPLE    = 3'd1,
    CFG_OVER_TEMP      = 3'd2,
    CFG_MIN_FLOW       = 3'd3,
    CFG_STUCK          = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_OVER_TEMP = 3'd1,
    CAUSE_LOW_FLOW  = 3'd2,
    CAUSE_STUCK     = 3'd3,
    CAUSE_FUSE_OPEN = 3'd4
  } cause_t;

  localparam logic        KIND_CHECK = 1'b0;
  localparam logic        KIND_CLEAR = 1'b1;

  localparam logic [15:0]        RST_EMERGENCY_HOLD = 16'd5000;
  localparam logic [15:0]        RST_FUSE_SAMPLE    = 16'd100;
  localparam logic signed [15:0] RST_OVER_TEMP      = 16'sd7000;
  localparam logic [15:0]        RST_MIN_FLOW       = 16'd50;
  localparam logic [15:0]        RST_STUCK          = 16'd2000;

  // packed MSB first; shutdown_event lands in bit 7, system_enabled in bit 0
  typedef struct packed {
    logic   shutdown_event;
    cause_t trip_cause;
    logic   emergency_active;
    logic   system_safe;
    logic   fuse_ok;
    logic   system_enabled;
  } result_t;

endpackage

@@ rtl/core/heater_safety_interlock.sv @@
// ----------------------------------------------------------------------------
// heater_safety_interlock
// Heater interlock: hold-time recovery, periodic fuse sampling, over
// temperature, low flow and stuck-reading trips, fuse-open shutdown.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_*    | in  | tuser: kind; tdata: now_ms, temperature, flow_rate, fuse_pin
//  out_*   | out | tdata: system_enabled ... shutdown_event (one result per item)
//  cfg_*   | in  | register write: cfg_addr, cfg_wdata
//
//  One item per cycle while in_tready is high; each result is registered,
//  into the skid if the output is held. All checks run in the accept cycle
//  against the state registers, so back-to-back items see each other's
//  updates. A two-entry output buffer (output register plus skid) keeps
//  in_tready high while one result waits; in_tready drops only when both are full.
//  rst_n is synchronous: config and interlock state return to defaults.
// ----------------------------------------------------------------------------
`include "heater_safety_interlock_defines.svh"

module heater_safety_interlock (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: now_ms[31:0], temperature[47:32], flow_rate[63:48], fuse_pin[64]
  input  logic [hsi_pkg::InDataW-1:0]   in_tdata,
  // in_tuser: kind[0]
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: system_enabled[0], fuse_ok[1], system_safe[2],
  //            emergency_active[3], trip_cause[6:4], shutdown_event[7]
  output logic [hsi_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [hsi_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [hsi_pkg::CfgDataW-1:0]  cfg_wdata
);

  // configuration
  logic [15:0]        hold_ms_r;
  logic [15:0]        sample_ms_r;
  logic signed [15:0] temp_limit_r;
  logic [15:0]        min_flow_r;
  logic [15:0]        stuck_ms_r;

  // interlock state
  logic               emerg_r,       emerg_nxt;
  logic [31:0]        emerg_start_r, emerg_start_nxt;
  logic               fuse_r,        fuse_nxt;
  logic [31:0]        last_sample_r, last_sample_nxt;
  logic               ref_valid_r,   ref_valid_nxt;
  logic signed [15:0] ref_temp_r,    ref_temp_nxt;
  logic [15:0]        ref_flow_r,    ref_flow_nxt;
  logic [31:0]        last_change_r, last_change_nxt;
  logic               enabled_r,     enabled_nxt;

  // output buffer
  hsi_pkg::result_t   out_r, skd_r, res;
  logic               out_valid_r, skd_valid_r;

  // input fields
  logic               kind;
  logic [31:0]        now_ms;
  logic signed [15:0] temperature;
  logic [15:0]        flow_rate;
  logic               fuse_pin;

  logic               in_fire, out_pop;
  logic [31:0]        since_start, since_sample, since_change;
  logic               em_mid;
  hsi_pkg::cause_t    cause;
  logic               event_flag;

  assign kind        = in_tuser;
  assign now_ms      = in_tdata[31:0];
  assign temperature = in_tdata[47:32];
  assign flow_rate   = in_tdata[63:48];
  assign fuse_pin    = in_tdata[64];

  assign in_tready  = !skd_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_pop    = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign since_start  = now_ms - emerg_start_r;
  assign since_sample = now_ms - last_sample_r;
  assign since_change = now_ms - last_change_r;

  always_comb begin
    emerg_nxt       = emerg_r;
    emerg_start_nxt = emerg_start_r;
    fuse_nxt        = fuse_r;
    last_sample_nxt = last_sample_r;
    ref_valid_nxt   = ref_valid_r;
    ref_temp_nxt    = ref_temp_r;
    ref_flow_nxt    = ref_flow_r;
    last_change_nxt = last_change_r;
    enabled_nxt     = enabled_r;
    cause           = hsi_pkg::CAUSE_NONE;
    event_flag      = 1'b0;
    em_mid          = emerg_r;

    if (kind == hsi_pkg::KIND_CLEAR) begin
      emerg_nxt = 1'b0;
    end else begin
      // hold time over: leave emergency and re-enable
      if (emerg_r && (since_start > {16'd0, hold_ms_r})) begin
        em_mid      = 1'b0;
        enabled_nxt = 1'b1;
      end
      emerg_nxt = em_mid;
      if (!em_mid) begin
        if (since_sample >= {16'd0, sample_ms_r}) begin
          fuse_nxt        = fuse_pin;
          last_sample_nxt = now_ms;
        end
        if (temperature > temp_limit_r) begin
          cause = hsi_pkg::CAUSE_OVER_TEMP;
        end else if ((flow_rate != 16'd0) && (flow_rate < min_flow_r)) begin
          cause = hsi_pkg::CAUSE_LOW_FLOW;
        end else if (!ref_valid_r || (temperature != ref_temp_r) ||
                     (flow_rate != ref_flow_r)) begin
          ref_valid_nxt   = 1'b1;
          ref_temp_nxt    = temperature;
          ref_flow_nxt    = flow_rate;
          last_change_nxt = now_ms;
        end else if (since_change > {16'd0, stuck_ms_r}) begin
          cause = hsi_pkg::CAUSE_STUCK;
        end
      end
      if (!fuse_nxt && (cause == hsi_pkg::CAUSE_NONE)) begin
        cause = hsi_pkg::CAUSE_FUSE_OPEN;
      end
      // any trip, open fuse or emergency still on: enter emergency if not in it, drop enable
      if ((cause != hsi_pkg::CAUSE_NONE) || em_mid) begin
        if (!em_mid) begin
          emerg_nxt       = 1'b1;
          emerg_start_nxt = now_ms;
          event_flag      = 1'b1;
        end
        enabled_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res.system_enabled   = enabled_nxt;
    res.fuse_ok          = fuse_nxt;
    res.system_safe      = fuse_nxt && !emerg_nxt;
    res.emergency_active = emerg_nxt;
    res.trip_cause       = cause;
    res.shutdown_event   = event_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ms_r    <= hsi_pkg::RST_EMERGENCY_HOLD;
      sample_ms_r  <= hsi_pkg::RST_FUSE_SAMPLE;
      temp_limit_r <= hsi_pkg::RST_OVER_TEMP;
      min_flow_r   <= hsi_pkg::RST_MIN_FLOW;
      stuck_ms_r   <= hsi_pkg::RST_STUCK;
    end else if (cfg_we) begin
      case (hsi_pkg::cfg_idx_t'(cfg_addr))
        hsi_pkg::CFG_EMERGENCY_HOLD: hold_ms_r    <= cfg_wdata;
        hsi_pkg::CFG_FUSE_SAMPLE:    sample_ms_r  <= cfg_wdata;
        hsi_pkg::CFG_OVER_TEMP:      temp_limit_r <= cfg_wdata;
        hsi_pkg::CFG_MIN_FLOW:       min_flow_r   <= cfg_wdata;
        hsi_pkg::CFG_STUCK:          stuck_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emerg_r       <= 1'b0;
      emerg_start_r <= '0;
      fuse_r        <= 1'b1;
      last_sample_r <= '0;
      ref_valid_r   <= 1'b0;
      ref_temp_r    <= '0;
      ref_flow_r    <= '0;
      last_change_r <= '0;
      enabled_r     <= 1'b1;
    end else if (in_fire) begin
      emerg_r       <= emerg_nxt;
      emerg_start_r <= emerg_start_nxt;
      fuse_r        <= fuse_nxt;
      last_sample_r <= last_sample_nxt;
      ref_valid_r   <= ref_valid_nxt;
      ref_temp_r    <= ref_temp_nxt;
      ref_flow_r    <= ref_flow_nxt;
      last_change_r <= last_change_nxt;
      enabled_r     <= enabled_nxt;
    end
  end

  // output register + skid; skid only fills when the output is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else if (skd_valid_r) begin
      if (out_pop) begin
        out_valid_r <= 1'b1;
        skd_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skd_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skd_valid_r) begin
      if (out_pop) begin
        out_r <= skd_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res;
      end else begin
        skd_r <= res;
      end
    end
  end

  `HSI_ASSERT(a_skid_implies_out, skd_valid_r |-> out_valid_r, "skid full with output empty")
  `HSI_ASSERT(a_ready_drop, $fell(in_tready) |-> $past(out_valid_r && !out_tready), "ready dropped without a held output")
  `HSI_ASSERT(a_event_disables, (out_valid_r && out_r.shutdown_event) |-> (out_r.emergency_active && !out_r.system_enabled), "shutdown beat without emergency")
  `HSI_ASSERT(a_safe_flag, out_valid_r |-> (out_r.system_safe == (out_r.fuse_ok && !out_r.emergency_active)), "system_safe inconsistent")
  `HSI_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> (!out_valid_r && !skd_valid_r), "output buffer not empty after reset")

endmodule

@@ sim/heater_safety_interlock_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heater_safety_interlock_tb
// Self-checking bench for the heater interlock. A directed table walks
// trips, recovery, fuse handling and time wrap, then randomized phases run
// under several register settings. Input and output streams both idle and
// stall in random bursts. Every status beat is checked against an in-bench
// model of the interlock, or for typed table rows against the stored status.
// ----------------------------------------------------------------------------
module heater_safety_interlock_tb;
  import hsi_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    logic               kind;
    logic [31:0]        now;
    logic signed [15:0] temp;
    logic [15:0]        flow;
    logic               pin;
    bit                 typed;
    result_t            status;
  } check_row_t;

  localparam result_t NO_STATUS = '0;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [InDataW-1:0]     in_tdata   = '0;
  logic                   in_tuser   = KIND_CHECK;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OutDataW-1:0]    out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CfgAddrW-1:0]    cfg_addr   = CFG_EMERGENCY_HOLD;
  logic [CfgDataW-1:0]    cfg_wdata  = '0;

  always #1 clk = ~clk;

  heater_safety_interlock dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // interlock model: registers
  logic [15:0]        hold_ms, sample_ms, min_flow_lim, stuck_lim;
  logic signed [15:0] temp_limit;
  // interlock model: state
  logic               emergency, fuse_good, ref_seen, heater_on;
  logic [31:0]        emergency_t0, fuse_sampled_at, changed_at;
  logic signed [15:0] ref_temp;
  logic [15:0]        ref_flow;

  result_t            pending_status[$];
  int                 mismatch_count = 0;
  int                 quiet_cycles   = 0;
  bit                 idle_en        = 1'b1;
  logic [31:0]        sim_now;
  logic signed [15:0] last_temp;
  logic [15:0]        last_flow;

  // status fields, high to low: shutdown, cause, emergency, safe, fuse_ok, enabled
  check_row_t dir_rows [24] = '{
    '{KIND_CHECK, 32'd0,     16'sd2000,  16'd300,   1'b1, 1'b1,
      '{1'b0, CAUSE_NONE, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{KIND_CHECK, 32'd150,   16'sd7001,  16'd300,   1'b1, 1'b1,
      '{1'b1, CAUSE_OVER_TEMP, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{KIND_CHECK, 32'd200,   16'sd7001,  16'd300,   1'b1, 1'b1,
      '{1'b0, CAUSE_NONE, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{KIND_CLEAR, 32'hFFFF_FFFF, 16'shFFFF, 16'hFFFF, 1'b0, 1'b1,
      '{1'b0, CAUSE_NONE, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{KIND_CHECK, 32'd300,   16'sd2000,  16'd300,   1'b1, 1'b0, NO_STATUS},
    // over temp and low flow together
    '{KIND_CHECK, 32'd400,   16'sd32767, 16'd10,    1'b1, 1'b0, NO_STATUS},
    '{KIND_CLEAR, 32'd400,   16'sd0,     16'd0,     1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd600,   16'sd2000,  16'd49,    1'b1, 1'b0, NO_STATUS},
    '{KIND_CLEAR, 32'd600,   16'sd0,     16'd0,     1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd700,   16'sh8000,  16'd0,     1'b1, 1'b0, NO_STATUS},
    // unchanged readings one ms past the stuck window
    '{KIND_CHECK, 32'd2701,  16'sh8000,  16'd0,     1'b1, 1'b0, NO_STATUS},
    '{KIND_CLEAR, 32'd2701,  16'sd0,     16'd0,     1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd2900,  16'sd100,   16'hFFFF,  1'b0, 1'b0, NO_STATUS},
    // fuse still open while already in emergency
    '{KIND_CHECK, 32'd3000,  16'sd100,   16'hFFFF,  1'b1, 1'b0, NO_STATUS},
    '{KIND_CLEAR, 32'd3000,  16'sd0,     16'd0,     1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd3050,  16'sd100,   16'hFFFF,  1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd3100,  16'sd7500,  16'hFFFF,  1'b1, 1'b0, NO_STATUS},
    // hold expires with the fault still there: re-entry on the same beat
    '{KIND_CHECK, 32'd8101,  16'sd7500,  16'hFFFF,  1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd13102, 16'sd2500,  16'd400,   1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'hFFFF_FF00, 16'sd2500, 16'd400, 1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'd16,    16'sd2500,  16'd401,   1'b1, 1'b0, NO_STATUS},
    '{KIND_CHECK, 32'h2000,  16'sd2500,  16'd401,   1'b1, 1'b0, NO_STATUS},
    // exactly at both limits: no trip
    '{KIND_CHECK, 32'h2000,  16'sd7000,  16'd50,    1'b1, 1'b0, NO_STATUS},
    '{KIND_CLEAR, 32'h2000,  16'sd0,     16'd0,     1'b1, 1'b0, NO_STATUS}
  };

  task automatic reset_model();
    hold_ms         = RST_EMERGENCY_HOLD;
    sample_ms       = RST_FUSE_SAMPLE;
    temp_limit      = RST_OVER_TEMP;
    min_flow_lim    = RST_MIN_FLOW;
    stuck_lim       = RST_STUCK;
    emergency       = 1'b0;
    emergency_t0    = '0;
    fuse_good       = 1'b1;
    fuse_sampled_at = '0;
    ref_seen        = 1'b0;
    ref_temp        = '0;
    ref_flow        = '0;
    changed_at      = '0;
    heater_on       = 1'b1;
  endtask

  function automatic logic start_emergency(input logic [31:0] now);
    if (emergency)
      return 1'b0;
    emergency    = 1'b1;
    emergency_t0 = now;
    return 1'b1;
  endfunction

  function automatic result_t interlock_step(input logic kind, input logic [31:0] now,
                                             input logic signed [15:0] temp,
                                             input logic [15:0] flow, input logic pin);
    cause_t  cause;
    logic    shut;
    result_t r;
    cause = CAUSE_NONE;
    shut  = 1'b0;
    if (kind == KIND_CLEAR) begin
      emergency = 1'b0;
    end else begin
      if (emergency && (now - emergency_t0) > 32'(hold_ms)) begin
        emergency = 1'b0;
        heater_on = 1'b1;
      end
      if (!emergency) begin
        if ((now - fuse_sampled_at) >= 32'(sample_ms)) begin
          fuse_good       = pin;
          fuse_sampled_at = now;
        end
        if (temp > temp_limit) begin
          cause = CAUSE_OVER_TEMP;
        end else if (flow != 16'd0 && flow < min_flow_lim) begin
          cause = CAUSE_LOW_FLOW;
        end else if (!ref_seen || temp != ref_temp || flow != ref_flow) begin
          ref_seen   = 1'b1;
          ref_temp   = temp;
          ref_flow   = flow;
          changed_at = now;
        end else if ((now - changed_at) > 32'(stuck_lim)) begin
          cause = CAUSE_STUCK;
        end
        if (cause != CAUSE_NONE)
          shut = start_emergency(now);
      end
      if (!fuse_good && cause == CAUSE_NONE)
        cause = CAUSE_FUSE_OPEN;
      if (!fuse_good || emergency) begin
        shut      = start_emergency(now) | shut;
        heater_on = 1'b0;
      end
    end
    r.system_enabled   = heater_on;
    r.fuse_ok          = fuse_good;
    r.system_safe      = fuse_good && !emergency;
    r.emergency_active = emergency;
    r.trip_cause       = cause;
    r.shutdown_event   = shut;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic push_beat(input logic kind, input logic [31:0] now,
                           input logic signed [15:0] temp, input logic [15:0] flow,
                           input logic pin, input bit typed, input result_t status);
    result_t model;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, pin, flow, temp, now};
    do @(posedge clk); while (!in_tready);
    model = interlock_step(kind, now, temp, flow, pin);
    pending_status.push_back(typed ? status : model);
    @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_EMERGENCY_HOLD: hold_ms      = val;
      CFG_FUSE_SAMPLE:    sample_ms    = val;
      CFG_OVER_TEMP:      temp_limit   = val;
      CFG_MIN_FLOW:       min_flow_lim = val;
      CFG_STUCK:          stuck_lim    = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] hold, input logic [15:0] sample,
                              input logic [15:0] limit, input logic [15:0] flow_min,
                              input logic [15:0] stuck);
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    set_reg(CFG_EMERGENCY_HOLD, hold);
    set_reg(CFG_FUSE_SAMPLE, sample);
    set_reg(CFG_OVER_TEMP, limit);
    set_reg(CFG_MIN_FLOW, flow_min);
    set_reg(CFG_STUCK, stuck);
    cfg_we <= 1'b0;
  endtask

  task automatic random_beat();
    logic               kind;
    logic signed [15:0] temp;
    logic [15:0]        flow;
    logic               pin;
    kind = ($urandom_range(0, 11) == 0) ? KIND_CLEAR : KIND_CHECK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: sim_now += 32'($urandom_range(0, 200));
      5, 6, 7:       sim_now += 32'($urandom_range(0, 3000));
      8:             sim_now += 32'($urandom_range(0, 12000));
      default:       sim_now  = $urandom;
    endcase
    temp = last_temp;
    flow = last_flow;
    // mostly repeat the readings so the stuck timer gets exercised
    if ($urandom_range(0, 9) >= 6) begin
      case ($urandom_range(0, 5))
        0, 1:    temp = temp_limit + 16'($urandom_range(0, 6)) - 16'd3;
        2:       temp = 16'($urandom_range(0, 9000));
        3:       temp = 16'($urandom);
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0:       flow = '0;
        1, 2:    flow = min_flow_lim + 16'($urandom_range(0, 4)) - 16'd2;
        3:       flow = 16'($urandom_range(0, 2000));
        4:       flow = 16'($urandom);
        default: ;
      endcase
    end
    pin       = ($urandom_range(0, 7) != 0);
    last_temp = temp;
    last_flow = flow;
    push_beat(kind, sim_now, temp, flow, pin, 1'b0, NO_STATUS);
  endtask

  // result side: random stall bursts
  always @(negedge clk) begin
    int stall_left;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected status beat %02h at %0t", out_tdata, $realtime);
      end else begin
        want = pending_status.pop_front();
        if (got.system_enabled !== want.system_enabled || got.fuse_ok !== want.fuse_ok ||
            got.system_safe !== want.system_safe ||
            got.emergency_active !== want.emergency_active ||
            got.trip_cause !== want.trip_cause || got.shutdown_event !== want.shutdown_event)
        begin
          mismatch_count++;
          // en/fuse/safe/emerg cause shut
          if (mismatch_count <= 10)
            $display("status mismatch at %0t: exp %b%b%b%b %0d %b got %b%b%b%b %0d %b",
                     $realtime, want.system_enabled, want.fuse_ok, want.system_safe,
                     want.emergency_active, want.trip_cause, want.shutdown_event,
                     got.system_enabled, got.fuse_ok,
                     got.system_safe, got.emergency_active, got.trip_cause,
                     got.shutdown_event);
        end
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("heater_safety_interlock_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] hold, sample, limit, flow_min, stuck;
    reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      push_beat(dir_rows[i].kind, dir_rows[i].now, dir_rows[i].temp, dir_rows[i].flow,
                dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].status);

    sim_now   = 32'h0000_3000;
    last_temp = 16'sd2500;
    last_flow = 16'd400;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          hold = RST_EMERGENCY_HOLD; sample = RST_FUSE_SAMPLE; limit = RST_OVER_TEMP;
          flow_min = RST_MIN_FLOW; stuck = RST_STUCK;
        end
        1: begin
          hold = '0; sample = '0; limit = 16'h8000; flow_min = '0; stuck = '0;
        end
        2: begin
          hold = '1; sample = '1; limit = 16'h7FFF; flow_min = '1; stuck = '1;
        end
        3: begin
          hold = 16'd1; sample = 16'd1; limit = '0; flow_min = 16'd1; stuck = 16'd1;
        end
        default: begin
          hold     = 16'($urandom_range(0, 8000));
          sample   = 16'($urandom_range(0, 400));
          limit    = $urandom_range(0, 1) ? 16'($urandom_range(5000, 9000)) : 16'($urandom);
          flow_min = 16'($urandom_range(0, 200));
          stuck    = 16'($urandom_range(0, 3000));
        end
      endcase
      program_regs(hold, sample, limit, flow_min, stuck);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0)
          idle_en = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_beat();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("heater_safety_interlock_tb OK");
    else
      $display("heater_safety_interlock_tb NOT OK");
    $finish;
  end

endmodule
